// ===== hw/rtl/signed_sum_to_grouped_decimal_defines.svh =====
// Assertion macros for the signed_sum_to_grouped_decimal RTL, included by sgd_emit.
`ifndef SIGNED_SUM_TO_GROUPED_DECIMAL_DEFINES_SVH
`define SIGNED_SUM_TO_GROUPED_DECIMAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/sgd_pkg.sv =====
// Shared types and constants for the signed sum to grouped decimal block.
`default_nettype none

package sgd_pkg;

  localparam int unsigned FIELD_W = 24;  // width of each addend field on the bus

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_COMMA = 8'd44;

  typedef enum logic [1:0] {
    DAB_IDLE,
    DAB_ABS,
    DAB_SHIFT
  } dab_state_e;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SIGN,
    EM_DIGIT,
    EM_COMMA
  } em_state_e;

  // Handoff from the converter to the character emitter.
  typedef struct packed {
    logic done;
    logic neg;
  } sgd_conv_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sgd_dabble.sv =====
// Adder, magnitude and bit-serial double-dabble binary to BCD converter.
`default_nettype none

module sgd_dabble #(
  parameter int unsigned VALUE_BITS = 24,
  parameter int unsigned NDIG       = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [VALUE_BITS-1:0]   op_a_i,
  input  wire logic [VALUE_BITS-1:0]   op_b_i,
  output logic                         busy_o,
  output sgd_pkg::sgd_conv_t           conv_o,
  output logic [NDIG*4-1:0]            bcd_o
);

  localparam int unsigned SUM_W = VALUE_BITS + 1;
  localparam int unsigned BCD_W = NDIG * 4;
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  sgd_pkg::dab_state_e state_q, state_d;
  logic [SUM_W-1:0] mag_q, mag_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic [BCD_W-1:0] bcd_adj;

  // add-3 on every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < int'(NDIG); i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    case (state_q)
      sgd_pkg::DAB_IDLE: begin
        if (start_i) begin
          mag_d   = {op_a_i[VALUE_BITS-1], op_a_i} + {op_b_i[VALUE_BITS-1], op_b_i};
          state_d = sgd_pkg::DAB_ABS;
        end
      end
      sgd_pkg::DAB_ABS: begin
        neg_d   = mag_q[SUM_W-1];
        mag_d   = mag_q[SUM_W-1] ? (~mag_q + SUM_W'(1)) : mag_q;
        bcd_d   = '0;
        cnt_d   = CNT_W'(SUM_W);
        state_d = sgd_pkg::DAB_SHIFT;
      end
      sgd_pkg::DAB_SHIFT: begin
        bcd_d = {bcd_adj[BCD_W-2:0], mag_q[SUM_W-1]};
        mag_d = mag_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = sgd_pkg::DAB_IDLE;
        end
      end
      default: state_d = sgd_pkg::DAB_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgd_pkg::DAB_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign busy_o      = (state_q != sgd_pkg::DAB_IDLE);
  assign conv_o.done = done_q;
  assign conv_o.neg  = neg_q;
  assign bcd_o       = bcd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sgd_emit.sv =====
// Character sequencer: skips leading zeros, emits sign, digits and commas.
`default_nettype none

`include "signed_sum_to_grouped_decimal_defines.svh"

module sgd_emit #(
  parameter int unsigned NDIG = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sgd_pkg::sgd_conv_t conv_i,
  input  wire logic [NDIG*4-1:0]  bcd_i,
  output logic                    busy_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [7:0]              m_tdata_o,
  output logic                    m_tlast_o
);

  localparam int unsigned BCD_W = NDIG * 4;
  localparam int unsigned REM_W = $clog2(NDIG + 1);
  localparam logic [1:0]  GRP_INIT = 2'((NDIG - 1) % 3);

  sgd_pkg::em_state_e state_q, state_d;
  logic [BCD_W-1:0] sr_q, sr_d;
  logic [REM_W-1:0] rem_q, rem_d;    // digits still to send, top one included
  logic [1:0]       grp_q, grp_d;    // position of the top digit, mod 3
  logic             neg_q, neg_d;
  logic             ov_q, ov_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;
  logic             can_load;
  logic [1:0]       grp_dec;
  logic [3:0]       top;

  assign can_load = !ov_q || m_tready_i;
  assign grp_dec  = (grp_q == 2'd0) ? 2'd2 : (grp_q - 2'd1);
  assign top      = sr_q[BCD_W-1 -: 4];

  always_comb begin
    state_d = state_q;
    sr_d    = sr_q;
    rem_d   = rem_q;
    grp_d   = grp_q;
    neg_d   = neg_q;
    ov_d    = ov_q;
    char_d  = char_q;
    last_d  = last_q;
    if (ov_q && m_tready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      sgd_pkg::EM_IDLE: begin
        if (conv_i.done) begin
          sr_d    = bcd_i;
          neg_d   = conv_i.neg;
          rem_d   = REM_W'(NDIG);
          grp_d   = GRP_INIT;
          state_d = sgd_pkg::EM_SKIP;
        end
      end
      sgd_pkg::EM_SKIP: begin
        // one leading zero per cycle; a zero sum keeps its last digit
        if (top == 4'd0 && rem_q > REM_W'(1)) begin
          sr_d  = sr_q << 4;
          rem_d = rem_q - REM_W'(1);
          grp_d = grp_dec;
        end else begin
          state_d = neg_q ? sgd_pkg::EM_SIGN : sgd_pkg::EM_DIGIT;
        end
      end
      sgd_pkg::EM_SIGN: begin
        if (can_load) begin
          ov_d    = 1'b1;
          char_d  = sgd_pkg::CH_MINUS;
          last_d  = 1'b0;
          state_d = sgd_pkg::EM_DIGIT;
        end
      end
      sgd_pkg::EM_DIGIT: begin
        if (can_load) begin
          ov_d   = 1'b1;
          char_d = sgd_pkg::CH_ZERO + {4'd0, top};
          last_d = (rem_q == REM_W'(1));
          sr_d   = sr_q << 4;
          rem_d  = rem_q - REM_W'(1);
          grp_d  = grp_dec;
          if (rem_q == REM_W'(1)) begin
            state_d = sgd_pkg::EM_IDLE;
          end else if (grp_q == 2'd0) begin
            state_d = sgd_pkg::EM_COMMA;
          end else begin
            state_d = sgd_pkg::EM_DIGIT;
          end
        end
      end
      sgd_pkg::EM_COMMA: begin
        if (can_load) begin
          ov_d    = 1'b1;
          char_d  = sgd_pkg::CH_COMMA;
          last_d  = 1'b0;
          state_d = sgd_pkg::EM_DIGIT;
        end
      end
      default: state_d = sgd_pkg::EM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgd_pkg::EM_IDLE;
      rem_q   <= '0;
      grp_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      grp_q   <= grp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q   <= sr_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o     = (state_q != sgd_pkg::EM_IDLE);
  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = char_q;
  assign m_tlast_o  = last_q;

  `SGD_ASSERT_NOW(a_start_idle, clk_i, rst_ni, conv_i.done, state_q == sgd_pkg::EM_IDLE)
  `SGD_ASSERT_NOW(a_rem_live, clk_i, rst_ni, state_q != sgd_pkg::EM_IDLE, rem_q != '0)
  `SGD_ASSERT_NOW(a_comma_room, clk_i, rst_ni, state_q == sgd_pkg::EM_COMMA, rem_q >= REM_W'(3))
  `SGD_ASSERT_NEXT(a_last_ends, clk_i, rst_ni,
                   state_q == sgd_pkg::EM_DIGIT && can_load && rem_q == REM_W'(1),
                   state_q == sgd_pkg::EM_IDLE && ov_q && last_q)

endmodule

`default_nettype wire

// ===== hw/rtl/signed_sum_to_grouped_decimal.sv =====
// Top level: adds two signed operands and streams the sum as grouped decimal text.
//
// Each input request carries two signed operands; the block adds them with one
// bit of growth and returns the exact sum as ASCII text, most significant
// character first: a '-' for a negative sum, then the digits with a ',' between
// each group of three counted from the right. A zero sum is the single '0'.
// tlast marks the final character of each sum. Operands are the low VALUE_BITS
// bits of each 24-bit field read as two's complement; for VALUE_BITS above 24
// the missing upper bits read as zero. One request is worked on at a time, in
// order: accept, which registers the sum; forming the magnitude; bit-serial
// double dabble, one bit per cycle; the handoff to the emitter; dropping the
// leading zero digits; then the characters, which wait while the sink stalls.
// Without sink stalls the conversion shift loop is the longest of these steps.
// The next request is taken as soon as the last character sits in the output
// register, even if the sink has not yet taken it.
`default_nettype none

module signed_sum_to_grouped_decimal #(
  parameter int unsigned VALUE_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // [23:0] addend_a, [47:24] addend_b
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] text_char
  output logic             m_axis_tlast_o    // last_char
);

  // digits needed for magnitudes up to 2**VALUE_BITS
  localparam int unsigned NDIG  = ((VALUE_BITS + 1) * 3) / 10 + 1;
  localparam int unsigned EXT_W = (VALUE_BITS > sgd_pkg::FIELD_W) ? VALUE_BITS
                                                                  : sgd_pkg::FIELD_W;

  logic [EXT_W-1:0]      a_ext, b_ext;
  logic [VALUE_BITS-1:0] op_a, op_b;
  logic                  dab_busy, em_busy, start;
  sgd_pkg::sgd_conv_t    conv;
  logic [NDIG*4-1:0]     bcd;

  // zero-extend the fields, then keep the operand bits
  assign a_ext = EXT_W'(s_axis_tdata_i[23:0]);
  assign b_ext = EXT_W'(s_axis_tdata_i[47:24]);
  assign op_a  = a_ext[VALUE_BITS-1:0];
  assign op_b  = b_ext[VALUE_BITS-1:0];

  // idle only once converter and emitter are both free and no handoff is pending
  assign s_axis_tready_o = !dab_busy && !em_busy && !conv.done;
  assign start           = s_axis_tvalid_i && s_axis_tready_o;

  sgd_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .busy_o  (dab_busy),
    .conv_o  (conv),
    .bcd_o   (bcd)
  );

  sgd_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .conv_i     (conv),
    .bcd_i      (bcd),
    .busy_o     (em_busy),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
